[rtl/core/brfp_pkg.sv]
// ----------------------------------------------------------------------------
// brfp_pkg: shared types and constants for the byte ring FIFO
// Field widths of the command and result beats and the operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package brfp_pkg;

  // Width of one stored byte.
  localparam int BYTE_W = 8;

  // Width of the request and granted-length fields.
  localparam int GRANT_W = 7;

  // Width of the fill-level and free-space fields.
  localparam int LEVEL_W = 11;

  // Operation carried by a command beat.
  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

endpackage

`default_nettype wire

[rtl/core/brfp_ram.sv]
// ----------------------------------------------------------------------------
// brfp_ram: byte storage of the ring FIFO
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brfp_ram #(
  parameter int AW = 10
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [brfp_pkg::BYTE_W-1:0] wr_data,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [brfp_pkg::BYTE_W-1:0] rd_data
);

  logic [brfp_pkg::BYTE_W-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, read every cycle.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/byte_ring_fifo_with_peek_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_unit: byte ring FIFO with put, get, peek, status
// Ring buffer of DEPTH bytes in one synchronous RAM, addressed by wrapping
// read and write pointers one bit wider than the slot index.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (in_mode, in_data_byte, in_request_len) is taken at a
//   rising edge where start is high and busy is low. Results appear on the
//   out_ ports for one cycle each, marked by out_valid; the receiver cannot
//   stall, so every result is taken in the cycle it is shown.
//   Put, status, and any get or peek that yields no byte give one result in
//   the cycle after the command; busy stays low, so these commands may be
//   issued every cycle.
//   A get or peek that yields n bytes (n up to MAX_REQUEST) reads the RAM
//   once per cycle: the first byte appears in the cycle after the command and
//   the rest follow on consecutive cycles, the last one marked out_is_last.
//   busy stays high after the command until the last byte is read, so such a
//   command holds the single RAM read port for its whole run.
//   fill and free space in every result are the values after the command.
//   Reset empties the FIFO (both pointers cleared); the RAM is not cleared,
//   since only bytes that were written are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_peek_unit #(
  parameter int DEPTH       = 1024,
  parameter int MAX_REQUEST = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [brfp_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic [brfp_pkg::GRANT_W-1:0] in_request_len,
  output logic                              out_valid,
  output logic [brfp_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_byte_valid,
  output logic                              out_is_last,
  output logic                              out_ok,
  output logic [brfp_pkg::GRANT_W-1:0]      out_granted_len,
  output logic [brfp_pkg::LEVEL_W-1:0]      out_fill_level,
  output logic [brfp_pkg::LEVEL_W-1:0]      out_free_space
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > brfp_pkg::GRANT_W) ? PW : brfp_pkg::GRANT_W;
  localparam int LW = (PW > brfp_pkg::LEVEL_W) ? PW : brfp_pkg::LEVEL_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                        state_r;
  logic [PW-1:0]                 wptr_r;
  logic [PW-1:0]                 rptr_r;
  logic [PW-1:0]                 addr_r;
  logic [brfp_pkg::GRANT_W-1:0]  remain_r;
  logic                          out_valid_r;
  logic                          byte_valid_r;
  logic                          last_r;
  logic                          ok_r;
  logic [brfp_pkg::GRANT_W-1:0]  granted_r;
  logic [brfp_pkg::LEVEL_W-1:0]  fill_r;
  logic [brfp_pkg::LEVEL_W-1:0]  free_r;

  logic                          accept;
  brfp_pkg::mode_t               mode;
  logic [PW-1:0]                 fill;
  logic                          full;
  logic [brfp_pkg::GRANT_W-1:0]  req_sat;
  logic [CW-1:0]                 req_c;
  logic [CW-1:0]                 fill_c;
  logic [CW-1:0]                 n_c;
  logic [brfp_pkg::GRANT_W-1:0]  get_n;
  logic                          peek_ok;
  logic [PW-1:0]                 fill_after;
  logic [PW-1:0]                 free_after;
  logic [LW-1:0]                 fill_ext;
  logic [LW-1:0]                 free_ext;
  logic                          wr_en;
  logic [AW-1:0]                 rd_addr;
  logic [brfp_pkg::BYTE_W-1:0]   rd_data;

  assign busy   = (state_r == ST_RUN);
  assign accept = start && !busy;
  assign mode   = brfp_pkg::mode_t'(in_mode);

  // Occupancy and request clamping for the command at the ports.
  assign fill    = wptr_r - rptr_r;
  assign full    = fill[PW-1];
  assign req_sat = (in_request_len > brfp_pkg::GRANT_W'(MAX_REQUEST))
                   ? brfp_pkg::GRANT_W'(MAX_REQUEST) : in_request_len;
  assign req_c   = CW'(req_sat);
  assign fill_c  = CW'(fill);
  assign n_c     = (req_c < fill_c) ? req_c : fill_c;
  assign get_n   = n_c[brfp_pkg::GRANT_W-1:0];
  assign peek_ok = (req_sat != '0) && (req_c <= fill_c);

  // Fill level after the command, as reported in its results.
  always_comb begin
    fill_after = fill;
    unique case (mode)
      brfp_pkg::MODE_PUT:    fill_after = full ? fill : fill + PW'(1);
      brfp_pkg::MODE_GET:    fill_after = fill - PW'(get_n);
      brfp_pkg::MODE_PEEK:   fill_after = fill;
      brfp_pkg::MODE_STATUS: fill_after = fill;
      default:               fill_after = fill;
    endcase
  end

  assign free_after = PW'(DEPTH) - fill_after;
  assign fill_ext   = LW'(fill_after);
  assign free_ext   = LW'(free_after);

  // RAM ports: puts write at the write pointer, reads stream from the
  // read pointer on the command cycle and from addr_r during a run.
  assign wr_en   = accept && (mode == brfp_pkg::MODE_PUT) && !full;
  assign rd_addr = busy ? addr_r[AW-1:0] : rptr_r[AW-1:0];

  brfp_ram #(
    .AW (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wptr_r[AW-1:0]),
    .wr_data (in_data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state, pointers and registered result fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wptr_r      <= '0;
      rptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_valid_r  <= 1'b1;
            byte_valid_r <= 1'b0;
            last_r       <= 1'b1;
            ok_r         <= 1'b0;
            granted_r    <= '0;
            fill_r       <= fill_ext[brfp_pkg::LEVEL_W-1:0];
            free_r       <= free_ext[brfp_pkg::LEVEL_W-1:0];
            addr_r       <= rptr_r + PW'(1);
            unique case (mode)
              brfp_pkg::MODE_PUT: begin
                if (!full) begin
                  wptr_r    <= wptr_r + PW'(1);
                  ok_r      <= 1'b1;
                  granted_r <= brfp_pkg::GRANT_W'(1);
                end
              end
              brfp_pkg::MODE_GET: begin
                if (get_n != '0) begin
                  rptr_r       <= rptr_r + PW'(get_n);
                  byte_valid_r <= 1'b1;
                  ok_r         <= 1'b1;
                  granted_r    <= get_n;
                  last_r       <= (get_n == brfp_pkg::GRANT_W'(1));
                  remain_r     <= get_n - brfp_pkg::GRANT_W'(1);
                  if (get_n != brfp_pkg::GRANT_W'(1)) begin
                    state_r <= ST_RUN;
                  end
                end
              end
              brfp_pkg::MODE_PEEK: begin
                if (peek_ok) begin
                  byte_valid_r <= 1'b1;
                  ok_r         <= 1'b1;
                  granted_r    <= req_sat;
                  last_r       <= (req_sat == brfp_pkg::GRANT_W'(1));
                  remain_r     <= req_sat - brfp_pkg::GRANT_W'(1);
                  if (req_sat != brfp_pkg::GRANT_W'(1)) begin
                    state_r <= ST_RUN;
                  end
                end
              end
              brfp_pkg::MODE_STATUS: begin
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          // One byte beat per cycle; length and levels hold for the run.
          out_valid_r  <= 1'b1;
          byte_valid_r <= 1'b1;
          last_r       <= (remain_r == brfp_pkg::GRANT_W'(1));
          remain_r     <= remain_r - brfp_pkg::GRANT_W'(1);
          addr_r       <= addr_r + PW'(1);
          if (remain_r == brfp_pkg::GRANT_W'(1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result ports; a beat without a byte shows zero.
  assign out_valid       = out_valid_r;
  assign out_byte        = byte_valid_r ? rd_data : '0;
  assign out_byte_valid  = byte_valid_r;
  assign out_is_last     = last_r;
  assign out_ok          = ok_r;
  assign out_granted_len = granted_r;
  assign out_fill_level  = fill_r;
  assign out_free_space  = free_r;

`ifndef SYNTHESIS
  // A run cycle always yields a byte beat in the next cycle.
  a_run_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && out_byte_valid))
    else $error("run cycle did not yield a byte beat");

  // A put or status command gives exactly one closing beat next cycle.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == brfp_pkg::MODE_PUT || in_mode == brfp_pkg::MODE_STATUS))
    |=> (out_valid && out_is_last && !out_byte_valid && !busy))
    else $error("put or status did not give one closing beat");

  // A byte beat is only ever part of a granted request.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_valid) |-> (out_ok && out_granted_len != '0))
    else $error("byte beat without a grant");

  // Fill and free space always add up to the depth.
  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (brfp_pkg::LEVEL_W'(out_fill_level + out_free_space)
                   == brfp_pkg::LEVEL_W'(DEPTH)))
    else $error("fill and free space do not add up to depth");

  // The FIFO never holds more bytes than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill <= PW'(DEPTH)))
    else $error("pointer distance exceeds depth");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for byte_ring_fifo_with_peek_unit
// Sends put, get, peek and status commands with random gaps. A mirror of the
// ring predicts each result beat, and every beat on the out_ ports is checked
// field by field against the oldest beat still due.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int MAX_REQUEST = 64;
  localparam int IDX_W       = $clog2(DEPTH);

  // One result beat as the unit shows it.
  typedef struct {
    logic [brfp_pkg::BYTE_W-1:0]  data;
    logic                         has_byte;
    logic                         last;
    logic                         ok;
    logic [brfp_pkg::GRANT_W-1:0] granted;
    logic [brfp_pkg::LEVEL_W-1:0] fill;
    logic [brfp_pkg::LEVEL_W-1:0] space;
  } beat_t;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic [1:0]                   in_mode        = '0;
  logic [brfp_pkg::BYTE_W-1:0]  in_data_byte   = '0;
  logic [brfp_pkg::GRANT_W-1:0] in_request_len = '0;
  logic                         out_valid;
  logic [brfp_pkg::BYTE_W-1:0]  out_byte;
  logic                         out_byte_valid;
  logic                         out_is_last;
  logic                         out_ok;
  logic [brfp_pkg::GRANT_W-1:0] out_granted_len;
  logic [brfp_pkg::LEVEL_W-1:0] out_fill_level;
  logic [brfp_pkg::LEVEL_W-1:0] out_free_space;

  // Mirror of the ring: byte slots and the two wrapping pointers.
  logic [brfp_pkg::BYTE_W-1:0]  ring_mem [DEPTH];
  logic [brfp_pkg::LEVEL_W-1:0] ring_wr = '0;
  logic [brfp_pkg::LEVEL_W-1:0] ring_rd = '0;

  beat_t due_beats[$];
  int    err_count = 0;

  byte_ring_fifo_with_peek_unit #(
    .DEPTH       (DEPTH),
    .MAX_REQUEST (MAX_REQUEST)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .in_request_len  (in_request_len),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_is_last     (out_is_last),
    .out_ok          (out_ok),
    .out_granted_len (out_granted_len),
    .out_fill_level  (out_fill_level),
    .out_free_space  (out_free_space)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bytes held by the mirror; pointers wrap modulo twice the depth.
  function automatic int ring_fill();
    logic [brfp_pkg::LEVEL_W-1:0] diff;
    diff = ring_wr - ring_rd;
    return int'(diff);
  endfunction

  // Queue one due beat; fill and free space are taken after the update.
  function automatic void push_beat(logic [brfp_pkg::BYTE_W-1:0] data, logic has_byte,
                                    logic last, logic ok, int granted);
    beat_t b;
    b.data     = data;
    b.has_byte = has_byte;
    b.last     = last;
    b.ok       = ok;
    b.granted  = brfp_pkg::GRANT_W'(granted);
    b.fill     = brfp_pkg::LEVEL_W'(ring_fill());
    b.space    = brfp_pkg::LEVEL_W'(DEPTH - ring_fill());
    due_beats.push_back(b);
  endfunction

  // Apply one accepted command to the mirror and queue the beats it causes.
  function automatic void ring_apply(brfp_pkg::mode_t mode,
                                     logic [brfp_pkg::BYTE_W-1:0] data,
                                     logic [brfp_pkg::GRANT_W-1:0] len);
    int                           req;
    int                           level;
    int                           n;
    logic [brfp_pkg::LEVEL_W-1:0] p;
    req   = (int'(len) > MAX_REQUEST) ? MAX_REQUEST : int'(len);
    level = ring_fill();
    case (mode)
      brfp_pkg::MODE_PUT: begin
        if (level < DEPTH) begin
          ring_mem[ring_wr[IDX_W-1:0]] = data;
          ring_wr = ring_wr + 1'b1;
          push_beat('0, 1'b0, 1'b1, 1'b1, 1);
        end else begin
          push_beat('0, 1'b0, 1'b1, 1'b0, 0);
        end
      end
      brfp_pkg::MODE_GET: begin
        n = (req < level) ? req : level;
        if (n == 0) begin
          push_beat('0, 1'b0, 1'b1, 1'b0, 0);
        end else begin
          p = ring_rd;
          ring_rd = ring_rd + brfp_pkg::LEVEL_W'(n);
          for (int i = 0; i < n; i++) begin
            push_beat(ring_mem[p[IDX_W-1:0]], 1'b1, i == n - 1, 1'b1, n);
            p = p + 1'b1;
          end
        end
      end
      brfp_pkg::MODE_PEEK: begin
        // A peek delivers only when every requested byte is held.
        if (req == 0 || req > level) begin
          push_beat('0, 1'b0, 1'b1, 1'b0, 0);
        end else begin
          p = ring_rd;
          for (int i = 0; i < req; i++) begin
            push_beat(ring_mem[p[IDX_W-1:0]], 1'b1, i == req - 1, 1'b1, req);
            p = p + 1'b1;
          end
        end
      end
      default: begin
        push_beat('0, 1'b0, 1'b1, 1'b0, 0);
      end
    endcase
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Every beat shown by the unit is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (due_beats.size() == 0) begin
        err_count++;
        $display("%0t: beat with none due, expected none, actual byte %0d fill %0d",
                 $time, out_byte, out_fill_level);
      end else begin
        want = due_beats.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_byte_valid", want.has_byte, out_byte_valid);
        check_field("out_is_last", want.last, out_is_last);
        check_field("out_ok", want.ok, out_ok);
        check_field("out_granted_len", want.granted, out_granted_len);
        check_field("out_fill_level", want.fill, out_fill_level);
        check_field("out_free_space", want.space, out_free_space);
      end
    end
  end

  // Present one command and hold it until the unit takes it.
  task automatic send_cmd(brfp_pkg::mode_t mode, logic [brfp_pkg::BYTE_W-1:0] data,
                          logic [brfp_pkg::GRANT_W-1:0] len);
    in_mode        <= mode;
    in_data_byte   <= data;
    in_request_len <= len;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    ring_apply(mode, data, len);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  // Mostly no gap or a short one, now and then a long one.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly short runs, some up to the cap, a few zero or above the cap.
  function automatic logic [brfp_pkg::GRANT_W-1:0] random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return brfp_pkg::GRANT_W'($urandom_range(1, 8));
    if (r < 90) return brfp_pkg::GRANT_W'($urandom_range(9, MAX_REQUEST));
    return brfp_pkg::GRANT_W'($urandom_range(0, 127));
  endfunction

  // Commands on an empty ring, including zero-length requests.
  task automatic test_empty_fifo();
    send_cmd(brfp_pkg::MODE_STATUS, 8'h00, 7'd0);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd1);
    send_cmd(brfp_pkg::MODE_PEEK, 8'hFF, 7'd1);
    idle_for(2);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd0);
    send_cmd(brfp_pkg::MODE_PEEK, 8'h00, 7'd0);
  endtask

  // A few bytes: short peek fails, full peek, single get and a saturated get clamped to what is left.
  task automatic test_small_runs();
    send_cmd(brfp_pkg::MODE_PUT, 8'h00, 7'd0);
    send_cmd(brfp_pkg::MODE_PUT, 8'hFF, 7'd127);
    send_cmd(brfp_pkg::MODE_PUT, 8'hA5, 7'd0);
    send_cmd(brfp_pkg::MODE_PUT, 8'h5A, 7'd0);
    send_cmd(brfp_pkg::MODE_PEEK, 8'h00, 7'd5);
    send_cmd(brfp_pkg::MODE_PEEK, 8'h00, 7'd0);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd0);
    send_cmd(brfp_pkg::MODE_PEEK, 8'h00, 7'd4);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd1);
    idle_for(1);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd127);
    send_cmd(brfp_pkg::MODE_STATUS, 8'h00, 7'd0);
  endtask

  // More bytes than the cap: saturated peeks and gets, then a get clamped to
  // what is left and one on the emptied ring.
  task automatic test_capped_runs();
    for (int i = 0; i < 72; i++) begin
      send_cmd(brfp_pkg::MODE_PUT, brfp_pkg::BYTE_W'($urandom_range(0, 255)),
               random_len());
      if ($urandom_range(0, 9) == 0) idle_for(random_gap());
    end
    send_cmd(brfp_pkg::MODE_STATUS, 8'h00, 7'd0);
    send_cmd(brfp_pkg::MODE_PEEK, 8'h00, 7'd127);
    send_cmd(brfp_pkg::MODE_PEEK, 8'h00, 7'd64);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd127);
    idle_for(random_gap());
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd64);
    send_cmd(brfp_pkg::MODE_GET, 8'h00, 7'd64);
  endtask

  // Random mix; one stretch runs without gaps and one pause drains the unit.
  task automatic test_random_traffic(int count);
    int              r;
    brfp_pkg::mode_t mode;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) mode = brfp_pkg::MODE_PUT;
      else if (r < 70) mode = brfp_pkg::MODE_GET;
      else if (r < 90) mode = brfp_pkg::MODE_PEEK;
      else mode = brfp_pkg::MODE_STATUS;
      send_cmd(mode, brfp_pkg::BYTE_W'($urandom_range(0, 255)), random_len());
      if (i == count / 2) pause_until_drained();
      else if (i < 30 || i >= 60) idle_for(random_gap());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_fifo();
    test_small_runs();
    test_capped_runs();
    test_random_traffic(90);
    // Wait for the last beats, then watch a while for stray ones.
    pause_until_drained();
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
